/* hdl/knob_chase_light_engine_defines.svh */
// Assertion macros shared by the knob chase light engine modules.
`ifndef KNOB_CHASE_LIGHT_ENGINE_DEFINES_SVH
`define KNOB_CHASE_LIGHT_ENGINE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define KCLE_ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define KCLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KCLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/kcle_pkg.sv */
// Types, constants and the LED position table of the knob chase light engine.
`default_nettype none

package kcle_pkg;

    // Configuration port geometry
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Spot geometry
    localparam int unsigned TABLE_SIZE  = 18;
    localparam int unsigned POS_RING    = 512;
    localparam int unsigned FULL_BRIGHT = 16;
    localparam int unsigned MOVE_STEP   = 16;
    localparam int unsigned DEAD_ZONE   = 6;

    // Colour weights of the left and right spot
    localparam logic [7:0] RED_WL   = 8'd70;
    localparam logic [7:0] RED_WR   = 8'd250;
    localparam logic [7:0] GREEN_WL = 8'd230;
    localparam logic [7:0] GREEN_WR = 8'd60;
    localparam logic [7:0] BLUE_WL  = 8'd250;
    localparam logic [7:0] BLUE_WR  = 8'd200;

    // Register reset values
    localparam logic [15:0] RST_STEP_PER_PULSE  = 16'd109;
    localparam logic [14:0] RST_COUNTER_LIMIT   = 15'd6554;
    localparam logic [14:0] RST_MOVE_THRESHOLD  = 15'd3277;
    localparam logic [14:0] RST_DECAY_STEP      = 15'd197;
    localparam logic [1:0]  RST_KNOB_REVERSE    = 2'd0;
    localparam logic [9:0]  RST_LEFT_START_POS  = 10'd416;
    localparam logic [9:0]  RST_RIGHT_START_POS = 10'd96;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_PER_PULSE  = 3'd0,
        CFG_COUNTER_LIMIT   = 3'd1,
        CFG_MOVE_THRESHOLD  = 3'd2,
        CFG_DECAY_STEP      = 3'd3,
        CFG_KNOB_REVERSE    = 3'd4,
        CFG_LEFT_START_POS  = 3'd5,
        CFG_RIGHT_START_POS = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] step_per_pulse;
        logic [14:0] counter_limit;
        logic [14:0] move_threshold;
        logic [14:0] decay_step;
        logic [1:0]  knob_reverse;
        logic [9:0]  left_start_pos;
        logic [9:0]  right_start_pos;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_UPD,
        S_LED
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic       ld_in;
        logic       knob;
        logic       do_diff;
        logic       do_mul;
        logic       do_upd;
        logic       led_issue;
        logic [4:0] led_index;
        logic [4:0] tab_idx;
        logic       led_last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic issue_ok;
    } t_sts;

    // LED base positions in 1/32 units
    function automatic logic [9:0] led_base(input logic [4:0] idx);
        logic [9:0] pos;
        case (idx)
            5'd0:    pos = 10'd128;
            5'd1:    pos = 10'd149;
            5'd2:    pos = 10'd171;
            5'd3:    pos = 10'd192;
            5'd4:    pos = 10'd96;
            5'd5:    pos = 10'd64;
            5'd6:    pos = 10'd64;
            5'd7:    pos = 10'd64;
            5'd8:    pos = 10'd448;
            5'd9:    pos = 10'd448;
            5'd10:   pos = 10'd448;
            5'd11:   pos = 10'd416;
            5'd12:   pos = 10'd384;
            5'd13:   pos = 10'd363;
            5'd14:   pos = 10'd341;
            5'd15:   pos = 10'd320;
            5'd16:   pos = 10'd256;
            5'd17:   pos = 10'd256;
            default: pos = 10'd0;
        endcase
        return pos;
    endfunction

endpackage

`default_nettype wire

/* hdl/kcle_if.sv */
// Handshake channels of the knob chase light engine: tick input, LED output, register writes.
`default_nettype none

interface kcle_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_count;
    logic [31:0] right_count;

    modport source (output valid, output left_count, output right_count, input ready);
    modport sink (input valid, input left_count, input right_count, output ready);
endinterface

interface kcle_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;

    modport source (output valid, output led_index, output red, output green, output blue,
                    output last, input ready);
    modport sink (input valid, input led_index, input red, input green, input blue,
                  input last, output ready);
endinterface

interface kcle_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [kcle_pkg::CFG_IDX_W-1:0]   index;
    logic [kcle_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/knob_chase_light_engine.sv */
// Top level of the knob chase light engine.
// Each input item carries the raw counts of the left and right knob encoders and yields
// LED_COUNT result items, one colour per LED in index order, last set on the final one.
// The controller first runs the knob update through a shared subtract, multiply and
// clamp/update step, one knob after the other, then issues one LED per cycle, while the
// output is not stalled, into a two-stage strength and colour pipe; the next item is
// accepted as soon as the last LED has been issued, while the pipe drains.
// Output stalls hold the pipe and the LED issue. Registers are written through the
// configuration channel, which is always ready; write them only while no item is in flight.
`default_nettype none

module knob_chase_light_engine #(
    parameter int unsigned LED_COUNT = 18
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    kcle_in_if.sink      i_in,
    kcle_out_if.source   o_out,
    kcle_cfg_if.sink     i_cfg
);

    kcle_pkg::t_cfg cfg;
    kcle_pkg::t_cmd cmd;
    kcle_pkg::t_sts sts;
    logic           in_ready;

    assign i_in.ready = in_ready;

    // Registers
    kcle_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Sequencer
    kcle_ctrl #(
        .LED_COUNT (LED_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath
    kcle_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (cfg),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

`default_nettype wire

/* hdl/kcle_cfg.sv */
// Configuration register file of the knob chase light engine.
`default_nettype none

module kcle_cfg (
    input  wire              i_clk,
    input  wire              i_rst_n,
    kcle_cfg_if.sink         i_cfg,
    output kcle_pkg::t_cfg   o_cfg
);

    kcle_pkg::t_cfg r_cfg;

    // Always take writes
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Load the addressed register, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_per_pulse  <= kcle_pkg::RST_STEP_PER_PULSE;
            r_cfg.counter_limit   <= kcle_pkg::RST_COUNTER_LIMIT;
            r_cfg.move_threshold  <= kcle_pkg::RST_MOVE_THRESHOLD;
            r_cfg.decay_step      <= kcle_pkg::RST_DECAY_STEP;
            r_cfg.knob_reverse    <= kcle_pkg::RST_KNOB_REVERSE;
            r_cfg.left_start_pos  <= kcle_pkg::RST_LEFT_START_POS;
            r_cfg.right_start_pos <= kcle_pkg::RST_RIGHT_START_POS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                kcle_pkg::CFG_STEP_PER_PULSE:  r_cfg.step_per_pulse  <= i_cfg.data[15:0];
                kcle_pkg::CFG_COUNTER_LIMIT:   r_cfg.counter_limit   <= i_cfg.data[14:0];
                kcle_pkg::CFG_MOVE_THRESHOLD:  r_cfg.move_threshold  <= i_cfg.data[14:0];
                kcle_pkg::CFG_DECAY_STEP:      r_cfg.decay_step      <= i_cfg.data[14:0];
                kcle_pkg::CFG_KNOB_REVERSE:    r_cfg.knob_reverse    <= i_cfg.data[1:0];
                kcle_pkg::CFG_LEFT_START_POS:  r_cfg.left_start_pos  <= i_cfg.data[9:0];
                kcle_pkg::CFG_RIGHT_START_POS: r_cfg.right_start_pos <= i_cfg.data[9:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/kcle_ctrl.sv */
// Sequencer of the knob chase light engine: knob updates, then one LED per unstalled cycle.
`default_nettype none

`include "knob_chase_light_engine_defines.svh"

module kcle_ctrl #(
    parameter int unsigned LED_COUNT = 18
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  kcle_pkg::t_sts   i_sts,
    output kcle_pkg::t_cmd   o_cmd
);

    localparam int unsigned IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
    localparam logic [4:0] TAB_LAST = 5'(kcle_pkg::TABLE_SIZE - 1);

    kcle_pkg::t_state r_state, n_state;
    logic             r_knob, n_knob;
    logic [IDX_W-1:0] r_led_cnt, n_led_cnt;
    logic [4:0]       r_tab_idx, n_tab_idx;
    kcle_pkg::t_cmd   cmd;

    assign o_cmd = cmd;

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kcle_pkg::S_IDLE;
            r_knob    <= 1'b0;
            r_led_cnt <= '0;
            r_tab_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_knob    <= n_knob;
            r_led_cnt <= n_led_cnt;
            r_tab_idx <= n_tab_idx;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state       = r_state;
        n_knob        = r_knob;
        n_led_cnt     = r_led_cnt;
        n_tab_idx     = r_tab_idx;
        o_in_ready    = 1'b0;
        cmd           = '0;
        cmd.knob      = r_knob;
        cmd.led_index = 5'(r_led_cnt);
        cmd.tab_idx   = r_tab_idx;
        cmd.led_last  = (r_led_cnt == LAST_IDX);
        case (r_state)
            kcle_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.ld_in = 1'b1;
                    n_state   = kcle_pkg::S_DIFF;
                end
            end
            kcle_pkg::S_DIFF: begin
                cmd.do_diff = 1'b1;
                n_state     = kcle_pkg::S_MUL;
            end
            kcle_pkg::S_MUL: begin
                cmd.do_mul = 1'b1;
                n_state    = kcle_pkg::S_UPD;
            end
            kcle_pkg::S_UPD: begin
                cmd.do_upd = 1'b1;
                n_knob     = ~r_knob;
                if (r_knob) begin
                    n_state   = kcle_pkg::S_LED;
                    n_led_cnt = '0;
                    n_tab_idx = '0;
                end else begin
                    n_state = kcle_pkg::S_DIFF;
                end
            end
            kcle_pkg::S_LED: begin
                if (i_sts.issue_ok) begin
                    cmd.led_issue = 1'b1;
                    n_tab_idx     = (r_tab_idx == TAB_LAST) ? 5'd0 : r_tab_idx + 5'd1;
                    if (r_led_cnt == LAST_IDX) begin
                        n_led_cnt = '0;
                        n_state   = kcle_pkg::S_IDLE;
                    end else begin
                        n_led_cnt = r_led_cnt + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = kcle_pkg::S_IDLE;
            end
        endcase
    end

    `KCLE_ASSERT_HOLDS(a_tab_range, r_tab_idx <= TAB_LAST, "LED table index out of range")
    `KCLE_ASSERT_NEXT(a_last_to_idle, cmd.led_issue && cmd.led_last, r_state == kcle_pkg::S_IDLE, "last LED issue did not return to idle")
    `KCLE_ASSERT_IMP(a_idle_clean, r_state == kcle_pkg::S_IDLE, (r_led_cnt == '0) && !r_knob, "idle with stale LED count or knob select")

endmodule

`default_nettype wire

/* hdl/kcle_dp.sv */
// Datapath of the knob chase light engine: knob state update and the two-stage LED colour pipe.
`default_nettype none

`include "knob_chase_light_engine_defines.svh"

module kcle_dp (
    input  wire              i_clk,
    input  wire              i_rst_n,
    kcle_in_if.sink          i_in,
    kcle_out_if.source       o_out,
    input  kcle_pkg::t_cfg   i_cfg,
    input  kcle_pkg::t_cmd   i_cmd,
    output kcle_pkg::t_sts   o_sts
);

    localparam logic signed [32:0] DELTA_MAX = 33'sd65536;
    localparam logic signed [11:0] RING      = 12'(kcle_pkg::POS_RING);
    localparam logic signed [11:0] STEP      = 12'(kcle_pkg::MOVE_STEP);
    localparam logic signed [16:0] DZ        = 17'(kcle_pkg::DEAD_ZONE);
    localparam logic [4:0]         FULL      = 5'(kcle_pkg::FULL_BRIGHT);

    // Knob state
    logic [31:0]        r_prev [2];
    logic signed [15:0] r_cnt  [2];
    logic [9:0]         r_pos  [2];
    logic [4:0]         r_bri  [2];

    // Per-tick working registers
    logic [31:0]        r_now [2];
    logic signed [17:0] r_delta, n_delta;
    logic signed [34:0] r_prod, n_prod;

    // LED pipe
    logic        r_a_vld;
    logic [11:0] r_sl, r_sr;
    logic [4:0]  r_a_idx;
    logic        r_a_last;
    logic        r_o_vld;
    logic [4:0]  r_o_idx;
    logic [7:0]  r_red, r_green, r_blue;
    logic        r_o_last;
    logic        o_adv;

    // Combinational knob update
    logic               k;
    logic [31:0]        w_diff;
    logic signed [32:0] w_sd, w_dsel;
    logic signed [16:0] w_step;
    logic signed [35:0] w_acc, w_lim, w_clamp;
    logic signed [16:0] w_c, w_thr, w_dec, w_cdec;
    logic [4:0]         w_bri_dec, n_bri;
    logic signed [11:0] w_p0, w_start, w_pb, w_p, n_pos;
    logic [9:0]         w_base;
    logic [11:0]        n_sl, n_sr;

    function automatic logic [11:0] spot_str(input logic [9:0] pos, input logic [4:0] bri,
                                             input logic [9:0] base);
        logic signed [10:0] d;
        logic [10:0]        ad;
        logic [6:0]         dc;
        d  = $signed({1'b0, pos}) - $signed({1'b0, base});
        ad = d[10] ? 11'(-d) : 11'(d);
        dc = (ad > 11'd64) ? 7'd64 : ad[6:0];
        return 12'(7'd64 - dc) * 12'(bri);
    endfunction

    function automatic logic [7:0] chan(input logic [11:0] sl, input logic [11:0] sr,
                                        input logic [7:0] wl, input logic [7:0] wr);
        logic [20:0] sum;
        logic [10:0] v;
        sum = 21'(sl) * 21'(wl) + 21'(sr) * 21'(wr);
        v   = sum[20:10];
        return (v > 11'd255) ? 8'd255 : v[7:0];
    endfunction

    assign k = i_cmd.knob;

    // Count change, reversed if asked, bounded so the product still saturates alike
    always_comb begin
        w_diff = r_now[k] - r_prev[k];
        w_sd   = $signed({w_diff[31], w_diff});
        w_dsel = i_cfg.knob_reverse[k] ? -w_sd : w_sd;
        if (w_dsel > DELTA_MAX) begin
            n_delta = 18'(DELTA_MAX);
        end else if (w_dsel < -DELTA_MAX) begin
            n_delta = 18'(-DELTA_MAX);
        end else begin
            n_delta = w_dsel[17:0];
        end
    end

    // Scale by the per-pulse step
    assign w_step = $signed({1'b0, i_cfg.step_per_pulse});
    assign n_prod = 35'(r_delta) * 35'(w_step);

    // Accumulate, clamp, move or fade the spot, then decay
    always_comb begin
        w_acc   = 36'(r_cnt[k]) + 36'(r_prod);
        w_lim   = $signed({21'd0, i_cfg.counter_limit});
        if (w_acc < -w_lim) begin
            w_clamp = -w_lim;
        end else if (w_acc > w_lim) begin
            w_clamp = w_lim;
        end else begin
            w_clamp = w_acc;
        end
        w_c   = w_clamp[16:0];
        w_thr = $signed({2'b0, i_cfg.move_threshold});
        w_dec = $signed({2'b0, i_cfg.decay_step});

        w_p0      = $signed({2'b0, r_pos[k]});
        w_start   = k ? $signed({2'b0, i_cfg.right_start_pos})
                      : $signed({2'b0, i_cfg.left_start_pos});
        w_bri_dec = (r_bri[k] == 5'd0) ? 5'd0 : r_bri[k] - 5'd1;
        if (w_bri_dec > FULL) begin
            w_bri_dec = FULL;
        end
        w_pb = w_p0;
        if (w_c < -w_thr) begin
            w_p   = w_p0 + STEP;
            n_bri = FULL;
        end else if (w_c > w_thr) begin
            w_p   = w_p0 - STEP;
            n_bri = FULL;
        end else begin
            n_bri = w_bri_dec;
            w_pb  = (w_bri_dec == 5'd0) ? w_start : w_p0;
            if (w_c < -DZ) begin
                w_p = w_pb + $signed({7'd0, w_bri_dec});
            end else if (w_c > DZ) begin
                w_p = w_pb - $signed({7'd0, w_bri_dec});
            end else begin
                w_p = w_pb;
            end
        end
        if (w_p < 12'sd0) begin
            n_pos = w_p + RING;
        end else if (w_p > RING) begin
            n_pos = w_p - RING;
        end else begin
            n_pos = w_p;
        end

        if (w_c < -w_dec) begin
            w_cdec = w_c + w_dec;
        end else if (w_c > w_dec) begin
            w_cdec = w_c - w_dec;
        end else begin
            w_cdec = w_c;
        end
    end

    // Strengths of both spots at the issued LED
    assign w_base = kcle_pkg::led_base(i_cmd.tab_idx);
    assign n_sl   = spot_str(r_pos[0], r_bri[0], w_base);
    assign n_sr   = spot_str(r_pos[1], r_bri[1], w_base);

    // Pipe advance and status
    assign o_adv          = !r_o_vld || o_out.ready;
    assign o_sts.issue_ok = !r_a_vld || o_adv;

    // Knob state and pipe valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev[0] <= '0;
            r_prev[1] <= '0;
            r_cnt[0]  <= '0;
            r_cnt[1]  <= '0;
            r_pos[0]  <= '0;
            r_pos[1]  <= '0;
            r_bri[0]  <= '0;
            r_bri[1]  <= '0;
            r_a_vld   <= 1'b0;
            r_o_vld   <= 1'b0;
        end else begin
            if (i_cmd.do_diff) begin
                r_prev[k] <= r_now[k];
            end
            if (i_cmd.do_upd) begin
                r_cnt[k] <= w_cdec[15:0];
                r_pos[k] <= n_pos[9:0];
                r_bri[k] <= n_bri;
            end
            if (i_cmd.led_issue) begin
                r_a_vld <= 1'b1;
            end else if (o_adv) begin
                r_a_vld <= 1'b0;
            end
            if (o_adv) begin
                r_o_vld <= r_a_vld;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_now[0] <= i_in.left_count;
            r_now[1] <= i_in.right_count;
        end
        if (i_cmd.do_diff) begin
            r_delta <= n_delta;
        end
        if (i_cmd.do_mul) begin
            r_prod <= n_prod;
        end
        if (i_cmd.led_issue) begin
            r_sl     <= n_sl;
            r_sr     <= n_sr;
            r_a_idx  <= i_cmd.led_index;
            r_a_last <= i_cmd.led_last;
        end
        if (o_adv && r_a_vld) begin
            r_o_idx  <= r_a_idx;
            r_o_last <= r_a_last;
            r_red    <= chan(r_sl, r_sr, kcle_pkg::RED_WL, kcle_pkg::RED_WR);
            r_green  <= chan(r_sl, r_sr, kcle_pkg::GREEN_WL, kcle_pkg::GREEN_WR);
            r_blue   <= chan(r_sl, r_sr, kcle_pkg::BLUE_WL, kcle_pkg::BLUE_WR);
        end
    end

    assign o_out.valid     = r_o_vld;
    assign o_out.led_index = r_o_idx;
    assign o_out.red       = r_red;
    assign o_out.green     = r_green;
    assign o_out.blue      = r_blue;
    assign o_out.last      = r_o_last;

    `KCLE_ASSERT_HOLDS(a_bri_full, (r_bri[0] <= FULL) && (r_bri[1] <= FULL), "spot brightness above full")
    `KCLE_ASSERT_HOLDS(a_pos_ring, (r_pos[0] <= 10'd512) && (r_pos[1] <= 10'd512), "spot position off the ring")
    `KCLE_ASSERT_NEXT(a_pipe_hold, r_a_vld && r_o_vld && !o_out.ready, r_a_vld, "LED strengths lost while output stalled")

endmodule

`default_nettype wire

/* tb/kcle_colour_check.sv */
// Checker for the knob chase light engine: predicts each tick's LED colours and compares them.
module kcle_colour_check #(
    parameter int unsigned LED_COUNT = 18
) (
    input  logic i_clk,
    input  logic i_rst_n,
    kcle_in_if   i_in,
    kcle_out_if  i_out,
    kcle_cfg_if  i_cfg,
    output int   o_mismatches,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING        = int'(kcle_pkg::POS_RING);
    localparam int FULL        = int'(kcle_pkg::FULL_BRIGHT);
    localparam int STRIDE      = int'(kcle_pkg::MOVE_STEP);
    localparam int DEAD        = int'(kcle_pkg::DEAD_ZONE);
    localparam int TABLE_LEN   = int'(kcle_pkg::TABLE_SIZE);
    localparam int REACH       = 64;
    localparam int PRINT_LIMIT = 40;

    // LED positions on the ring, 1/32 units
    localparam int BASE_POS [kcle_pkg::TABLE_SIZE] = '{
        128, 149, 171, 192, 96, 64, 64, 64, 448,
        448, 448, 416, 384, 363, 341, 320, 256, 256
    };

    typedef struct packed {
        logic [4:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_led_colour;

    kcle_pkg::t_cfg regs;
    logic [31:0]    last_count [2];
    int             speed [2];
    int             spot_pos [2];
    int             spot_level [2];
    t_led_colour    colours_due [$];
    int             mismatch_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: LED %s mismatch, got %0d expected %0d", $time, what, got, want);
    endtask

    // Advance one knob by a tick: speed counter, spot position and brightness
    task automatic advance_knob(input int k, input logic [31:0] now, input logic [9:0] start);
        logic [31:0] diff;
        longint      delta;
        longint      acc;
        longint      lim;
        int          c;
        int          p;
        int          b;
        int          thr;
        int          dec;
        diff  = now - last_count[k];
        delta = longint'($signed(diff));
        if (regs.knob_reverse[k])
            delta = -delta;
        last_count[k] = now;

        // Accumulate at full width, then clamp
        lim = longint'(regs.counter_limit);
        acc = longint'(speed[k]) + delta * longint'(regs.step_per_pulse);
        if (acc < -lim)
            acc = -lim;
        if (acc > lim)
            acc = lim;
        c   = int'(acc);
        thr = int'(regs.move_threshold);
        dec = int'(regs.decay_step);

        p = spot_pos[k];
        b = spot_level[k];
        if (c < -thr) begin
            p = p + STRIDE;
            b = FULL;
        end else if (c > thr) begin
            p = p - STRIDE;
            b = FULL;
        end else begin
            // Fade; a dark spot returns to rest, a lit one creeps outside the dead zone
            b = (b > 0) ? b - 1 : 0;
            if (b > FULL)
                b = FULL;
            if (b == 0)
                p = int'(start);
            if (c < -DEAD)
                p = p + b;
            else if (c > DEAD)
                p = p - b;
        end
        if (p < 0)
            p = p + RING;
        if (p > RING)
            p = p - RING;

        // Decay toward zero
        if (c < -dec)
            c = c + dec;
        else if (c > dec)
            c = c - dec;

        speed[k]      = c;
        spot_pos[k]   = p & 'h3FF;
        spot_level[k] = b & 'h1F;
    endtask

    function automatic int light_strength(input int k, input int base);
        int d;
        d = spot_pos[k] - base;
        if (d < 0)
            d = -d;
        if (d > REACH)
            d = REACH;
        return (REACH - d) * spot_level[k];
    endfunction

    function automatic logic [7:0] blend(input int sl, input int sr, input int wl, input int wr);
        int v;
        v = (sl * wl + sr * wr) / 1024;
        if (v > 255)
            v = 255;
        if (v < 0)
            v = 0;
        return v[7:0];
    endfunction

    always @(posedge i_clk) begin : watch
        t_led_colour want;
        int          sl;
        int          sr;
        int          base;
        if (!i_rst_n) begin
            regs.step_per_pulse  = kcle_pkg::RST_STEP_PER_PULSE;
            regs.counter_limit   = kcle_pkg::RST_COUNTER_LIMIT;
            regs.move_threshold  = kcle_pkg::RST_MOVE_THRESHOLD;
            regs.decay_step      = kcle_pkg::RST_DECAY_STEP;
            regs.knob_reverse    = kcle_pkg::RST_KNOB_REVERSE;
            regs.left_start_pos  = kcle_pkg::RST_LEFT_START_POS;
            regs.right_start_pos = kcle_pkg::RST_RIGHT_START_POS;
            for (int k = 0; k < 2; k++) begin
                last_count[k] = '0;
                speed[k]      = 0;
                spot_pos[k]   = 0;
                spot_level[k] = 0;
            end
            colours_due.delete();
            mismatch_count = 0;
        end else begin
            // Track register writes; unknown indexes are dropped
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    kcle_pkg::CFG_STEP_PER_PULSE:  regs.step_per_pulse  = i_cfg.data[15:0];
                    kcle_pkg::CFG_COUNTER_LIMIT:   regs.counter_limit   = i_cfg.data[14:0];
                    kcle_pkg::CFG_MOVE_THRESHOLD:  regs.move_threshold  = i_cfg.data[14:0];
                    kcle_pkg::CFG_DECAY_STEP:      regs.decay_step      = i_cfg.data[14:0];
                    kcle_pkg::CFG_KNOB_REVERSE:    regs.knob_reverse    = i_cfg.data[1:0];
                    kcle_pkg::CFG_LEFT_START_POS:  regs.left_start_pos  = i_cfg.data[9:0];
                    kcle_pkg::CFG_RIGHT_START_POS: regs.right_start_pos = i_cfg.data[9:0];
                    default: ;
                endcase
            end

            // Accepted tick: update both knobs, queue one colour per LED
            if (i_in.valid && i_in.ready) begin
                advance_knob(0, i_in.left_count, regs.left_start_pos);
                advance_knob(1, i_in.right_count, regs.right_start_pos);
                for (int i = 0; i < LED_COUNT; i++) begin
                    base            = BASE_POS[i % TABLE_LEN];
                    sl              = light_strength(0, base);
                    sr              = light_strength(1, base);
                    want.led_index  = 5'(i);
                    want.red        = blend(sl, sr, kcle_pkg::RED_WL, kcle_pkg::RED_WR);
                    want.green      = blend(sl, sr, kcle_pkg::GREEN_WL, kcle_pkg::GREEN_WR);
                    want.blue       = blend(sl, sr, kcle_pkg::BLUE_WL, kcle_pkg::BLUE_WR);
                    want.last       = (i == LED_COUNT - 1);
                    colours_due.push_back(want);
                end
            end

            // Accepted colour: compare with the oldest one due
            if (i_out.valid && i_out.ready) begin
                if (colours_due.size() == 0) begin
                    report_mismatch("colour with none due, index", i_out.led_index, '0);
                end else begin
                    want = colours_due.pop_front();
                    if (i_out.led_index !== want.led_index)
                        report_mismatch("index", i_out.led_index, want.led_index);
                    if (i_out.red !== want.red)
                        report_mismatch("red", i_out.red, want.red);
                    if (i_out.green !== want.green)
                        report_mismatch("green", i_out.green, want.green);
                    if (i_out.blue !== want.blue)
                        report_mismatch("blue", i_out.blue, want.blue);
                    if (i_out.last !== want.last)
                        report_mismatch("last flag", i_out.last, want.last);
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= colours_due.size();
    end

endmodule

/* tb/knob_chase_light_engine_test.sv */
// Testbench top for the knob chase light engine: clock, reset, ticks, register writes, verdict.
module knob_chase_light_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LED_COUNT = 18;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [kcle_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int          mismatches;
    int          colours_pending;
    int          cycle_count = 0;
    int          hold_requests = 0;
    int          holds_done = 0;
    bit          source_gaps = 1'b1;
    bit          left_up = 1'b0;
    bit          right_up = 1'b1;
    logic [31:0] left_now;
    logic [31:0] right_now;

    kcle_in_if  in_ch ();
    kcle_out_if out_ch ();
    kcle_cfg_if cfg_ch ();

    knob_chase_light_engine #(.LED_COUNT(LED_COUNT)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    kcle_colour_check #(.LED_COUNT(LED_COUNT)) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_mismatches (mismatches),
        .o_pending    (colours_pending)
    );

    always #5 i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("knob_chase_light_engine test failed");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Next raw count: mostly a small turn in the drift direction, some rest, some jumps
    function automatic logic [31:0] next_count(input logic [31:0] cur, input bit up);
        int unsigned r;
        logic [31:0] m;
        r = $urandom_range(0, 99);
        if (r < 15)
            return cur;
        if (r < 75) begin
            m = $urandom_range(0, 80);
            return up ? cur + m : cur - m;
        end
        if (r < 93)
            return cur + 32'($urandom_range(0, 4000)) - 32'd2000;
        return $urandom();
    endfunction

    task automatic send_tick(input logic [31:0] left_count, input logic [31:0] right_count);
        int gap;
        gap = source_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.left_count  <= left_count;
        in_ch.right_count <= right_count;
        left_now  = left_count;
        right_now = right_count;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic nudge(input logic [31:0] dl, input logic [31:0] dr);
        send_tick(left_now + dl, right_now + dr);
    endtask

    task automatic random_ticks(input int n);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                left_up = !left_up;
            if ($urandom_range(0, 9) == 0)
                right_up = !right_up;
            send_tick(next_count(left_now, left_up), next_count(right_now, right_up));
        end
    endtask

    task automatic write_reg(input logic [kcle_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kcle_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic write_settings(input logic [15:0] step, input logic [15:0] limit,
                                  input logic [15:0] thr, input logic [15:0] dec,
                                  input logic [15:0] rev, input logic [15:0] left_start,
                                  input logic [15:0] right_start);
        write_reg(kcle_pkg::CFG_STEP_PER_PULSE, step);
        write_reg(kcle_pkg::CFG_COUNTER_LIMIT, limit);
        write_reg(kcle_pkg::CFG_MOVE_THRESHOLD, thr);
        write_reg(kcle_pkg::CFG_DECAY_STEP, dec);
        write_reg(kcle_pkg::CFG_KNOB_REVERSE, rev);
        write_reg(kcle_pkg::CFG_LEFT_START_POS, left_start);
        write_reg(kcle_pkg::CFG_RIGHT_START_POS, right_start);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drop valid, wait for every colour due, then let the pipe drain
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (colours_pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side: random stalls, stretches without stalls, and long hold-offs on request
    initial begin : result_sink
        int stall_left;
        bit stalls_on;
        stall_left = 0;
        stalls_on  = 1'b1;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (stalls_on)
                    stall_left = pick_gap();
            end
            if ($urandom_range(0, 199) == 0)
                stalls_on = !stalls_on;
        end
    end

    initial begin : stimulus
        in_ch.valid       <= 1'b0;
        in_ch.left_count  <= '0;
        in_ch.right_count <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= kcle_pkg::CFG_STEP_PER_PULSE;
        cfg_ch.data       <= '0;
        left_now  = '0;
        right_now = '0;
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks at reset settings
        // still knobs: dark spots load their rest positions
        send_tick(32'h0, 32'h0);
        // full-speed turns: left climbs past 512, right drops below zero
        repeat (8) nudge(-32'd100, 32'd100);
        // nearly cancel the counters: fade with creep
        nudge(32'd58, -32'd58);
        repeat (3) nudge(32'd0, 32'd0);
        // largest positive and negative count changes
        nudge(32'h7FFF_FFFF, 32'h8000_0000);
        nudge(32'h8000_0000, 32'h7FFF_FFFF);
        // field extremes
        send_tick(32'hFFFF_FFFF, 32'h0);
        send_tick(32'h0, 32'hFFFF_FFFF);
        repeat (3) nudge(32'd1, -32'd1);
        settle();

        // Low extremes, both knobs reversed
        write_settings(16'd1, 16'd0, 16'd0, 16'd0, 16'd3, 16'd0, 16'd512);
        source_gaps = ($urandom_range(0, 3) != 0);
        random_ticks(40);
        settle();

        // High extremes, rest positions beyond the ring end
        write_settings(16'd65535, 16'd32767, 16'd32767, 16'd32767, 16'd0, 16'd1023, 16'd513);
        source_gaps = ($urandom_range(0, 3) != 0);
        random_ticks(40);
        settle();

        // Fine steps: small counters reach the dead zone and creep both ways
        write_settings(16'd1, 16'd100, 16'd50, 16'd1, 16'd1, 16'd300, 16'd200);
        source_gaps = ($urandom_range(0, 3) != 0);
        random_ticks(45);
        settle();

        // Random legal settings under a long output hold-off, sender never idles
        write_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 32767)),
                       16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                       16'($urandom_range(0, 3)), 16'($urandom_range(0, 512)),
                       16'($urandom_range(0, 512)));
        source_gaps = 1'b0;
        hold_requests++;
        random_ticks(55);
        settle();

        // Raw register data with upper bits set, plus a write to an unused index
        write_reg(CFG_UNUSED, 16'($urandom()));
        write_settings(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                       16'($urandom()), 16'($urandom()), 16'($urandom()));
        source_gaps = ($urandom_range(0, 3) != 0);
        random_ticks(45);
        settle();

        // Back to reset values, right knob reversed
        write_settings(kcle_pkg::RST_STEP_PER_PULSE, kcle_pkg::RST_COUNTER_LIMIT,
                       kcle_pkg::RST_MOVE_THRESHOLD, kcle_pkg::RST_DECAY_STEP, 16'd2,
                       kcle_pkg::RST_LEFT_START_POS, kcle_pkg::RST_RIGHT_START_POS);
        source_gaps = 1'b1;
        random_ticks(55);
        settle();

        if (mismatches == 0)
            $display("knob_chase_light_engine test passed");
        else
            $display("knob_chase_light_engine test failed");
        $finish;
    end

endmodule

/* knob_chase_light_engine.f */
+incdir+hdl
hdl/kcle_pkg.sv
hdl/kcle_if.sv
hdl/kcle_cfg.sv
hdl/kcle_ctrl.sv
hdl/kcle_dp.sv
hdl/knob_chase_light_engine.sv
tb/kcle_colour_check.sv
tb/knob_chase_light_engine_test.sv
